// File: sv/bal_pkg.sv
// shared types and constants for the bounded array list
`default_nettype none
package bal_pkg;
	localparam int CAPACITY = 256;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = 8;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_RDWAIT = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_DONE   = 4'b1000
	} seq_state_t;
endpackage
`default_nettype wire

// File: sv/bounded_array_list.sv
// bounded array list top level with result output register
//
//  channel   direction  fields                         handshake
//  request   in         req_type, index, value         in_valid / in_stall
//  result    out        status, read_value, count      out_valid / out_stall
//
//  push and rejected requests go from idle straight to done, read passes through rdwait
//  remove passes through shift, which moves each entry above the index down, one entry
//  per cycle on the single ram port pair; removing the last entry skips the shift state
//  reset clears the length and handshake state, ram contents are not cleared
//  a stalled result sits in the output register while the next request runs
`default_nettype none
module bounded_array_list import bal_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               req_type,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [CNT_W-1:0]              count
);
	logic    res_valid;
	logic    res_take;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	bal_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.index    (index),
		.value    (value),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign read_value = out_q.read_value;
	assign count      = out_q.count;
endmodule
`default_nettype wire

// File: sv/bal_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: sv/bal_seq.sv
// request sequencer: push, read and one-entry-per-cycle compaction on remove
`default_nettype none
module bal_seq import bal_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               req_type,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          res_valid,
	input  wire logic                     res_take,
	output result_t                       res
);
	seq_state_t         state_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [1:0]         status_q;
	logic [DATA_W-1:0]  rdval_q;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [DATA_W-1:0]  wr_data;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [DATA_W-1:0]  rd_data;

	logic               accept;
	logic               full;
	logic [CMP_W-1:0]   idx_x;
	logic [CMP_W-1:0]   len_x;
	logic               idx_ok;
	logic [CMP_W:0]     idx_p1;
	logic               start_shift;
	logic [CNT_W:0]     ptr_p2;
	logic               more_shift;

	assign accept      = in_valid && (state_q == S_IDLE);
	assign in_stall    = (state_q != S_IDLE);
	assign full        = (len_q == CNT_W'(CAPACITY));
	assign idx_x       = CMP_W'(index);
	assign len_x       = CMP_W'(len_q);
	assign idx_ok      = idx_x < len_x;
	assign idx_p1      = {1'b0, idx_x} + 1'b1;
	assign start_shift = idx_p1 < {1'b0, len_x};
	assign ptr_p2      = {1'b0, ptr_q} + 2'd2;
	assign more_shift  = ptr_p2 < {1'b0, len_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(len_q);
		wr_data = value;
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(index);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_PUSH && !full) begin
						wr_en = 1'b1;
					end else if (req_type == REQ_REMOVE && idx_ok) begin
						rd_en   = 1'b1;
						rd_addr = ADDR_W'(idx_p1);
					end else if (req_type == REQ_READ && idx_ok) begin
						rd_en = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(ptr_q);
				wr_data = rd_data;
				rd_en   = more_shift;
				rd_addr = ADDR_W'(ptr_p2);
			end
			default: begin
			end
		endcase
	end

	bal_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						if (req_type == REQ_PUSH) begin
							if (!full) begin
								len_q <= len_q + 1'b1;
							end
						end else if (req_type == REQ_REMOVE) begin
							if (idx_ok) begin
								if (start_shift) begin
									state_q <= S_SHIFT;
								end else begin
									len_q <= len_q - 1'b1;
								end
							end
						end else if (req_type == REQ_READ) begin
							if (idx_ok) begin
								state_q <= S_RDWAIT;
							end
						end
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					if (!more_shift) begin
						state_q <= S_DONE;
						len_q   <= len_q - 1'b1;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload and shift pointer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q <= ST_OK;
					rdval_q  <= '0;
					ptr_q    <= CNT_W'(index);
					if (req_type == REQ_PUSH && full) begin
						status_q <= ST_FULL;
					end else if ((req_type == REQ_REMOVE || req_type == REQ_READ) && !idx_ok) begin
						status_q <= ST_RANGE;
					end
				end
			end
			S_RDWAIT: begin
				rdval_q <= rd_data;
			end
			S_SHIFT: begin
				ptr_q <= ptr_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.read_value  = rdval_q;
	assign res.count       = len_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	a_shift_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (({1'b0, ptr_q} + 1'b1) < {1'b0, len_q}))
		else $error("shift pointer outside the list");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write at one address");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_PUSH && !full) |=> (len_q == $past(len_q) + 1'b1))
		else $error("push did not grow the list");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_take) |=> (res_valid && $stable(len_q)))
		else $error("result dropped before hand-off");
endmodule
`default_nettype wire

// File: test/tb_bounded_array_list.sv
// bounded_array_list testbench: directed and random requests checked by a built-in predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_bounded_array_list import bal_pkg::*;;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AT_RESULT  = 120;
	localparam int SETTLE_CYCLES   = 300;
	localparam int REPORT_LIMIT    = 50;

	typedef struct packed {
		logic [1:0]               kind;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] val;
	} list_req_t;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic [1:0]               req_type   = REQ_PUSH;
	logic [IDX_W-1:0]         index      = '0;
	logic signed [DATA_W-1:0] value      = '0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         count;

	bounded_array_list dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	// list predictor state
	logic signed [DATA_W-1:0] list_store [CAPACITY];
	int                       list_len = 0;
	result_t                  expected_results [$];
	result_t                  next_expected;

	// request generation
	list_req_t pending_reqs [$];
	list_req_t next_req;
	int        gen_len        = 0;
	int        queued_total   = 0;
	int        accepted_total = 0;
	int        results_seen   = 0;
	logic      req_taken      = 1'b0;

	// sender and receiver pacing
	int       burst_left = 0;
	int       gap_left   = 0;
	int       hold_left  = 0;
	bit       hold_done  = 1'b0;
	int       mode_left  = 0;
	rx_mode_t stall_mode = RX_FLOW;

	int error_count = 0;
	int idle_cycles = 0;
	int n_push = 0, n_remove = 0, n_read = 0, n_unused = 0;
	int n_full = 0, n_range = 0, peak_len = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t list_step(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		result_t r;
		r.status     = ST_OK;
		r.read_value = '0;
		case (kind)
			REQ_PUSH: begin
				n_push++;
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					list_store[list_len] = val;
					list_len++;
				end
			end
			REQ_REMOVE: begin
				n_remove++;
				if (idx >= list_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					for (int i = idx; i + 1 < list_len; i++)
						list_store[i] = list_store[i + 1];
					list_len--;
				end
			end
			REQ_READ: begin
				n_read++;
				if (idx >= list_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					r.read_value = list_store[idx];
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		r.count = list_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			if (error_count < REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic queue_request(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		list_req_t item;
		item.kind = kind;
		item.idx  = idx;
		item.val  = val;
		pending_reqs.insert(pending_reqs.size(), item);
		queued_total++;
		if (kind == REQ_PUSH && gen_len < CAPACITY)
			gen_len++;
		else if (kind == REQ_REMOVE && idx < gen_len)
			gen_len--;
	endtask

	task automatic queue_random(input int push_pct, input int remove_pct);
		int                       r;
		logic [1:0]               kind;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < 3)
			kind = REQ_UNUSED;
		else if (r < 3 + push_pct)
			kind = REQ_PUSH;
		else if (r < 3 + push_pct + remove_pct)
			kind = REQ_REMOVE;
		else
			kind = REQ_READ;
		r = $urandom_range(0, 99);
		if (gen_len == 0 || r < 10)
			idx = IDX_W'($urandom_range(0, 255));
		else if (r < 20)
			idx = '0;
		else if (r < 30)
			idx = IDX_W'(gen_len - 1);
		else if (r < 35)
			idx = IDX_W'(gen_len);
		else
			idx = IDX_W'($urandom_range(0, gen_len - 1));
		r = $urandom_range(0, 99);
		if (r < 5)
			val = 32'h8000_0000;
		else if (r < 10)
			val = 32'h7FFF_FFFF;
		else
			val = $urandom;
		queue_request(kind, idx, val);
	endtask

	task automatic wait_drained();
		while (accepted_total != queued_total || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !req_taken) begin
			// stalled, hold the request
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_reqs.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			next_req = pending_reqs.pop_front();
			in_valid <= 1'b1;
			req_type <= next_req.kind;
			index    <= next_req.idx;
			value    <= next_req.val;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				                                          : $urandom_range(1, 12);
				gap_left   = $urandom_range(1, 10);
			end
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(30, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				RX_FLOW:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:  out_stall <= !out_stall;
			endcase
		end
	end

	// result checking and prediction of accepted requests
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (error_count < REPORT_LIMIT)
						$display("%0t: unexpected result: status %0d read_value %0h count %0d",
						         $time, status, read_value, count);
					error_count++;
				end else begin
					next_expected = expected_results.pop_front();
					check_field("status", next_expected.status, status);
					check_field("read_value", next_expected.read_value, read_value);
					check_field("count", next_expected.count, count);
				end
				results_seen++;
			end
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(),
				                        list_step(req_type, index, value));
				accepted_total++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog, nothing moved for %0d cycles", $time, idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// empty list corner cases
		queue_request(REQ_READ, 8'd0, 32'd0);
		queue_request(REQ_REMOVE, 8'd0, 32'd0);
		queue_request(REQ_REMOVE, 8'hFF, 32'hFFFF_FFFF);
		queue_request(REQ_UNUSED, 8'hFF, 32'h1234_5678);
		// value extremes, index ignored on push
		queue_request(REQ_PUSH, 8'd0, 32'h7FFF_FFFF);
		queue_request(REQ_PUSH, 8'hFF, 32'h8000_0000);
		queue_request(REQ_PUSH, 8'd0, 32'h0000_0000);
		queue_request(REQ_PUSH, 8'd0, 32'hFFFF_FFFF);
		queue_request(REQ_PUSH, 8'hAA, 32'h5555_5555);
		queue_request(REQ_PUSH, 8'h55, 32'hAAAA_AAAA);
		queue_request(REQ_READ, 8'd0, 32'd0);
		queue_request(REQ_READ, 8'd5, 32'd0);
		queue_request(REQ_READ, 8'd6, 32'd0);
		queue_request(REQ_READ, 8'hFF, 32'hFFFF_FFFF);
		// remove front, last and middle
		queue_request(REQ_REMOVE, 8'd0, 32'hDEAD_BEEF);
		queue_request(REQ_READ, 8'd0, 32'd0);
		queue_request(REQ_REMOVE, 8'd4, 32'd0);
		queue_request(REQ_REMOVE, 8'd1, 32'd0);
		queue_request(REQ_READ, 8'd1, 32'hFFFF_FFFF);
		queue_request(REQ_READ, 8'd3, 32'd0);
		queue_request(REQ_UNUSED, 8'd0, 32'd0);

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait_drained();

		// fill phase, long result hold-off lands here
		repeat (300) queue_random(85, 5);
		while (gen_len < CAPACITY)
			queue_request(REQ_PUSH, IDX_W'($urandom_range(0, 255)), $urandom);
		repeat (4) queue_request(REQ_PUSH, IDX_W'($urandom_range(0, 255)), $urandom);
		queue_request(REQ_READ, 8'hFF, $urandom);
		queue_request(REQ_REMOVE, 8'hFF, $urandom);
		queue_request(REQ_PUSH, 8'd0, $urandom);
		queue_request(REQ_PUSH, 8'd0, $urandom);
		queue_request(REQ_READ, 8'd0, $urandom);
		wait_drained();

		// mixed traffic on a full or nearly full list
		repeat (60) queue_random(35, 30);
		wait_drained();

		// shrink phase down to empty
		repeat (120) queue_random(10, 70);
		while (gen_len > 0)
			queue_request(REQ_REMOVE, IDX_W'($urandom_range(0, gen_len - 1)), $urandom);
		queue_request(REQ_READ, 8'd0, $urandom);
		queue_request(REQ_REMOVE, 8'd0, $urandom);
		queue_request(REQ_PUSH, IDX_W'($urandom_range(0, 255)), $urandom);
		queue_request(REQ_READ, 8'd0, $urandom);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d requests: %0d push, %0d remove, %0d read, %0d unused code",
		         accepted_total, n_push, n_remove, n_read, n_unused);
		$display("%0d full refusals, %0d out-of-range rejects, peak length %0d, %0d results",
		         n_full, n_range, peak_len, results_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
sv/bal_pkg.sv
sv/bal_ram.sv
sv/bal_seq.sv
sv/bounded_array_list.sv
test/tb_bounded_array_list.sv
